[design/olb_pkg.sv]
// Shared types and constants of the optimal line breaker.
// Field widths, register index and the command and status words between
// controller and datapath. Depends on nothing.
package olb_pkg;

   localparam int MaxBoxesDefault = 64;
   localparam int LenBits         = 16;
   localparam int IndexBits       = 6;
   localparam int GlueBits        = 24;
   localparam int CostBits        = 48;
   localparam int CsrAddrBits     = 3;
   localparam int CsrDataBits     = 32;
   localparam logic CsrLineWidth  = 1'b0;

   typedef struct packed {
      logic load;
      logic dp_init;
      logic row_rd;
      logic row_ld;
      logic cell_rd;
      logic cell_wb;
      logic cell_p;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic sum;
      logic pick;
      logic tb_init;
      logic tb_rd;
      logic tb_chk;
      logic div_start;
      logic emit_rd;
      logic emit;
      logic tb_next;
      logic done;
   } olb_cmd_type;

   typedef struct packed {
      logic row_end;
      logic w_zero;
      logic brk;
      logic tb_final;
      logic before_nz;
      logic div_busy;
      logic slot_free;
      logic emit_end;
      logic line_last;
   } olb_sts_type;

endpackage

[design/olb_req_if.sv]
// Input channel of the optimal line breaker: one box per word.
// Depends on olb_pkg.
interface olb_req_if;
   import olb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [LenBits-1:0]        box_width;
   logic [LenBits-1:0]        glue_nominal;
   logic [LenBits-1:0]        break_extra;
   logic signed [LenBits-1:0] break_penalty;
   logic                      last_box;

   modport source (output valid, box_width, glue_nominal, break_extra, break_penalty,
                   last_box, input ready);
   modport sink (input valid, box_width, glue_nominal, break_extra, break_penalty,
                 last_box, output ready);
endinterface

[design/olb_rsp_if.sv]
// Result channel of the optimal line breaker: one word per box.
// Depends on olb_pkg.
interface olb_rsp_if;
   import olb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [IndexBits-1:0]       box_index;
   logic                       line_break;
   logic                       glue_set;
   logic signed [GlueBits-1:0] glue_out;
   logic                       last_result;

   modport source (output valid, box_index, line_break, glue_set, glue_out,
                   last_result, input ready);
   modport sink (input valid, box_index, line_break, glue_set, glue_out,
                 last_result, output ready);
endinterface

[design/olb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olb_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[design/olb_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module olb_div #(
   parameter int DividendBits = 24,
   parameter int DivisorBits  = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DividendBits-1:0] dividend,
   input  logic [DivisorBits-1:0]  divisor,
   output logic                    busy,
   output logic [DividendBits-1:0] quotient
);
   localparam int CntBits = $clog2(DividendBits + 1);

   logic [DividendBits-1:0] quo_ff, quo_in;
   logic [DivisorBits-1:0]  rem_ff, rem_in, dvs_ff;
   logic [CntBits-1:0]      cnt_ff;
   logic                    busy_ff;
   logic [DivisorBits:0]    trial, diff;
   logic                    fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DividendBits-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in = {quo_ff[DividendBits-2:0], fits};
      rem_in = fits ? diff[DivisorBits-1:0] : trial[DivisorBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CntBits'(DividendBits);
      end else if (busy_ff) begin
         busy_ff <= cnt_ff != CntBits'(1);
         cnt_ff  <= cnt_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[design/olb_ctrl.sv]
// Sequencer of the optimal line breaker: load, table pass, trace back, emit.
// Depends on olb_pkg.
module olb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  olb_pkg::olb_sts_type sts,
   output olb_pkg::olb_cmd_type cmd
);
   import olb_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE    = 22'h000001,
      S_DP_INIT = 22'h000002,
      S_ROW_RD  = 22'h000004,
      S_ROW_LD  = 22'h000008,
      S_C_RD    = 22'h000010,
      S_C_WB    = 22'h000020,
      S_C_P     = 22'h000040,
      S_M1      = 22'h000080,
      S_M2      = 22'h000100,
      S_M3      = 22'h000200,
      S_M4      = 22'h000400,
      S_SUM     = 22'h000800,
      S_PICK    = 22'h001000,
      S_TB_INIT = 22'h002000,
      S_TB_RD   = 22'h004000,
      S_TB_CHK  = 22'h008000,
      S_DIV_S   = 22'h010000,
      S_DIV_W   = 22'h020000,
      S_E_RD    = 22'h040000,
      S_E_OUT   = 22'h080000,
      S_E_NEXT  = 22'h100000,
      S_DONE    = 22'h200000
   } olb_state_type;

   olb_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid && req_last) begin
                       state_in = S_DP_INIT;
                    end
         S_DP_INIT: state_in = S_ROW_RD;
         S_ROW_RD:  state_in = S_ROW_LD;
         S_ROW_LD:  state_in = S_C_RD;
         S_C_RD:    state_in = S_C_WB;
         S_C_WB:    state_in = S_C_P;
         S_C_P:     state_in = S_M1;
         S_M1:      state_in = S_M2;
         S_M2:      state_in = S_M3;
         S_M3:      state_in = S_M4;
         S_M4:      state_in = S_SUM;
         S_SUM:     state_in = S_PICK;
         S_PICK: begin
            priority if (!sts.row_end) begin
               state_in = S_C_RD;
            end else if (sts.w_zero) begin
               state_in = S_TB_INIT;
            end else begin
               state_in = S_ROW_RD;
            end
         end
         S_TB_INIT: state_in = S_TB_RD;
         S_TB_RD:   state_in = S_TB_CHK;
         S_TB_CHK: begin
            priority if (sts.brk && sts.before_nz) begin
               state_in = S_DIV_S;
            end else if (sts.brk || sts.tb_final) begin
               state_in = S_E_RD;
            end else begin
               state_in = S_TB_RD;
            end
         end
         S_DIV_S:   state_in = S_DIV_W;
         S_DIV_W:   if (!sts.div_busy) begin
                       state_in = S_E_RD;
                    end
         S_E_RD:    state_in = S_E_OUT;
         S_E_OUT: begin
            priority if (!sts.slot_free) begin
               state_in = S_E_OUT;
            end else if (!sts.emit_end) begin
               state_in = S_E_RD;
            end else if (sts.line_last) begin
               state_in = S_DONE;
            end else begin
               state_in = S_E_NEXT;
            end
         end
         S_E_NEXT:  state_in = S_TB_RD;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.dp_init   = state_ff == S_DP_INIT;
      cmd.row_rd    = state_ff == S_ROW_RD;
      cmd.row_ld    = state_ff == S_ROW_LD;
      cmd.cell_rd   = state_ff == S_C_RD;
      cmd.cell_wb   = state_ff == S_C_WB;
      cmd.cell_p    = state_ff == S_C_P;
      cmd.mul1      = state_ff == S_M1;
      cmd.mul2      = state_ff == S_M2;
      cmd.mul3      = state_ff == S_M3;
      cmd.mul4      = state_ff == S_M4;
      cmd.sum       = state_ff == S_SUM;
      cmd.pick      = state_ff == S_PICK;
      cmd.tb_init   = state_ff == S_TB_INIT;
      cmd.tb_rd     = state_ff == S_TB_RD;
      cmd.tb_chk    = state_ff == S_TB_CHK;
      cmd.div_start = state_ff == S_DIV_S;
      cmd.emit_rd   = state_ff == S_E_RD;
      cmd.emit      = (state_ff == S_E_OUT) && sts.slot_free;
      cmd.tb_next   = state_ff == S_E_NEXT;
      cmd.done      = state_ff == S_DONE;
   end
endmodule

[design/olb_dp.sv]
// Datapath of the optimal line breaker: box store, cost row, decision table,
// cube unit, divider and result register. Depends on olb_pkg, olb_ram, olb_div.
module olb_dp #(
   parameter int MaxBoxes = olb_pkg::MaxBoxesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  olb_pkg::olb_cmd_type                 cmd,
   output olb_pkg::olb_sts_type                 sts,
   input  logic [olb_pkg::LenBits-1:0]          box_width,
   input  logic [olb_pkg::LenBits-1:0]          glue_nominal,
   input  logic [olb_pkg::LenBits-1:0]          break_extra,
   input  logic signed [olb_pkg::LenBits-1:0]   break_penalty,
   input  logic                                 cfg_we,
   input  logic [olb_pkg::LenBits-1:0]          cfg_wdata,
   output logic [olb_pkg::LenBits-1:0]          line_len,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [olb_pkg::IndexBits-1:0]        rsp_box_index,
   output logic                                 rsp_line_break,
   output logic                                 rsp_glue_set,
   output logic signed [olb_pkg::GlueBits-1:0]  rsp_glue_out,
   output logic                                 rsp_last_result
);
   import olb_pkg::*;

   localparam int AW   = $clog2(MaxBoxes);
   localparam int CW   = $clog2(MaxBoxes + 1);
   localparam int BAW  = $clog2(MaxBoxes * MaxBoxes);
   localparam int PW   = LenBits + 1;
   localparam int UW   = PW + AW;
   localparam int AB   = PW + 1;
   localparam int MW   = 3 * AB - 8;
   localparam int OvW  = MW - 8;
   localparam int BoxBits = 4 * LenBits;
   localparam logic signed [UW+1:0] GlueHi = (UW+2)'(2 ** (GlueBits - 1) - 1);
   localparam logic signed [UW+1:0] GlueLo = -GlueHi - (UW+2)'(1);

   function automatic logic signed [CostBits-1:0] sat_add(
      input logic signed [CostBits-1:0] x,
      input logic signed [CostBits-1:0] y
   );
      logic [CostBits:0] s;
      s = {x[CostBits-1], x} + {y[CostBits-1], y};
      if (s[CostBits] != s[CostBits-1]) begin
         sat_add = s[CostBits] ? {1'b1, {(CostBits-1){1'b0}}} : {1'b0, {(CostBits-1){1'b1}}};
      end else begin
         sat_add = s[CostBits-1:0];
      end
   endfunction

   logic [CW-1:0]               count_ff;
   logic [LenBits-1:0]          lw_ff;
   logic [AW-1:0]               w_ff, b_ff, before_ff, start_ff, end_ff, i_ff;
   logic                        have_next_ff, line_brk_ff, neg_ff;
   logic signed [CostBits-1:0]  rest0_ff, cost0_ff, restn_ff, cb_ff, cn_ff;
   logic [LenBits-1:0]          wid_ff;
   logic [PW-1:0]               wbrk_ff, slack_ff;
   logic signed [LenBits-1:0]   pen_ff;
   logic [UW-1:0]               wb_ff, used_ff;
   logic [AB-1:0]               ab_ff, an_ff;
   logic                        en_b_ff, en_n_ff;
   logic [MW-1:0]               mul_ff;
   logic [OvW-1:0]              ovb_ff;
   logic                        rsp_valid_ff, brk_out_ff, gset_ff, last_ff;
   logic [IndexBits-1:0]        idx_ff;
   logic signed [GlueBits-1:0]  glue_ff;

   logic                        box_we, box_re;
   logic [AW-1:0]               box_raddr;
   logic [BoxBits-1:0]          box_rdata;
   logic [CostBits-1:0]         cost_rdata;
   logic [BAW-1:0]              bt_waddr, bt_raddr;
   logic                        bt_rdata;
   logic [LenBits-1:0]          rd_width, rd_glue, rd_extra;
   logic                        div_busy;
   logic [UW-1:0]               quot, div_mag;
   logic signed [UW:0]          left, sq;
   logic signed [UW+1:0]        gsum;
   logic signed [GlueBits-1:0]  glue_sat;
   logic [UW:0]                 wb_x, lw_x, tot_b, tot_n;
   logic [PW-1:0]               pb, pn, slack;
   logic                        over_b, over_n;
   logic signed [CostBits-1:0]  cb1, cb_in, cn_in, pick_cost;
   logic                        take, full, row_end, tb_final, line_end;
   logic [UW-1:0]               add_wg, add_we;

   assign rd_width = box_rdata[LenBits-1:0];
   assign rd_glue  = box_rdata[2*LenBits-1:LenBits];
   assign rd_extra = box_rdata[3*LenBits-1:2*LenBits];

   assign full     = count_ff >= CW'(MaxBoxes);
   assign box_we   = cmd.load && !full;
   assign box_re   = cmd.row_rd || cmd.cell_rd || cmd.tb_rd || cmd.emit_rd;
   always_comb begin
      priority if (cmd.cell_rd) begin
         box_raddr = w_ff - b_ff;
      end else if (cmd.emit_rd) begin
         box_raddr = i_ff;
      end else begin
         box_raddr = w_ff;
      end
   end

   olb_ram #(.Width(BoxBits), .Depth(MaxBoxes)) u_box_ram (
      .clock (clock),
      .we    (box_we),
      .waddr (AW'(count_ff)),
      .wdata ({break_penalty, break_extra, glue_nominal, box_width}),
      .re    (box_re),
      .raddr (box_raddr),
      .rdata (box_rdata)
   );

   olb_ram #(.Width(CostBits), .Depth(MaxBoxes)) u_cost_ram (
      .clock (clock),
      .we    (cmd.pick),
      .waddr (b_ff),
      .wdata (pick_cost),
      .re    (cmd.cell_rd),
      .raddr (b_ff + AW'(1)),
      .rdata (cost_rdata)
   );

   assign bt_waddr = BAW'(w_ff) * BAW'(MaxBoxes) + BAW'(b_ff);
   assign bt_raddr = BAW'(w_ff) * BAW'(MaxBoxes) + BAW'(before_ff);

   olb_ram #(.Width(1), .Depth(MaxBoxes * MaxBoxes)) u_brk_ram (
      .clock (clock),
      .we    (cmd.pick),
      .waddr (bt_waddr),
      .wdata (take),
      .re    (cmd.tb_rd),
      .raddr (bt_raddr),
      .rdata (bt_rdata)
   );

   assign left    = $signed({1'b0, UW'(lw_ff)}) - $signed({1'b0, used_ff});
   assign div_mag = left[UW] ? UW'(-left) : UW'(left);

   olb_div #(.DividendBits(UW), .DivisorBits(AW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_mag),
      .divisor  (before_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_comb begin
      wb_x   = (UW+1)'(wb_ff);
      lw_x   = (UW+1)'(lw_ff);
      tot_b  = wb_x + (UW+1)'(wbrk_ff);
      tot_n  = wb_x + (UW+1)'(wid_ff);
      over_b = tot_b > lw_x;
      over_n = tot_n > lw_x;
      pb     = (wb_x > lw_x) ? wbrk_ff : PW'(tot_b - lw_x);
      pn     = (wb_x > lw_x) ? PW'(wid_ff) : PW'(tot_n - lw_x);
      slack  = (lw_x > tot_b) ? PW'(lw_x - tot_b) : '0;
   end

   always_comb begin
      cb1   = CostBits'(pen_ff) + $signed(CostBits'(ovb_ff)) + $signed(CostBits'(slack_ff));
      cb_in = sat_add(cb1, rest0_ff);
      cn_in = sat_add($signed(CostBits'(en_n_ff ? mul_ff[MW-1:8] : '0)), restn_ff);
      take      = cb_ff < cn_ff;
      pick_cost = take ? cb_ff : cn_ff;
   end

   always_comb begin
      sq   = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      gsum = $signed((UW+2)'(rd_glue)) + (UW+2)'(sq);
      priority if (gsum > GlueHi) begin
         glue_sat = GlueBits'(GlueHi);
      end else if (gsum < GlueLo) begin
         glue_sat = GlueBits'(GlueLo);
      end else begin
         glue_sat = GlueBits'(gsum);
      end
   end

   assign row_end  = b_ff == w_ff;
   assign tb_final = (CW'(w_ff) + CW'(1)) == count_ff;
   assign line_end = bt_rdata || tb_final;
   assign add_wg   = UW'(rd_width) + UW'(rd_glue);
   assign add_we   = UW'(rd_width) + UW'(rd_extra);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            lw_ff <= cfg_wdata;
         end
         if (cmd.done) begin
            count_ff <= '0;
         end else if (box_we) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dp_init) begin
         w_ff         <= AW'(count_ff - CW'(1));
         have_next_ff <= 1'b0;
         rest0_ff     <= '0;
      end
      if (cmd.row_ld) begin
         wid_ff  <= rd_width;
         wbrk_ff <= PW'(rd_width) + PW'(rd_extra);
         pen_ff  <= $signed(box_rdata[BoxBits-1:3*LenBits]);
         wb_ff   <= '0;
         b_ff    <= '0;
      end
      if (cmd.cell_wb) begin
         if (b_ff != '0) begin
            wb_ff <= wb_ff + add_wg;
         end
         restn_ff <= have_next_ff ? $signed(cost_rdata) : '0;
      end
      if (cmd.cell_p) begin
         ab_ff    <= AB'(256) + AB'(pb);
         an_ff    <= AB'(256) + AB'(pn);
         en_b_ff  <= over_b && (pb != '0);
         en_n_ff  <= over_n && (pn != '0);
         slack_ff <= slack;
      end
      if (cmd.mul1) begin
         mul_ff <= MW'(ab_ff * ab_ff);
      end
      if (cmd.mul2) begin
         mul_ff <= MW'(mul_ff[2*AB-1:8] * ab_ff);
      end
      if (cmd.mul3) begin
         ovb_ff <= en_b_ff ? mul_ff[MW-1:8] : '0;
         mul_ff <= MW'(an_ff * an_ff);
      end
      if (cmd.mul4) begin
         mul_ff <= MW'(mul_ff[2*AB-1:8] * an_ff);
      end
      if (cmd.sum) begin
         cb_ff <= cb_in;
         cn_ff <= cn_in;
      end
      if (cmd.pick) begin
         if (b_ff == '0) begin
            cost0_ff <= pick_cost;
         end
         if (row_end) begin
            rest0_ff     <= (b_ff == '0) ? pick_cost : cost0_ff;
            have_next_ff <= 1'b1;
            w_ff         <= w_ff - AW'(1);
         end else begin
            b_ff <= b_ff + AW'(1);
         end
      end
      if (cmd.tb_init || cmd.tb_next) begin
         w_ff      <= cmd.tb_init ? '0 : end_ff + AW'(1);
         start_ff  <= cmd.tb_init ? '0 : end_ff + AW'(1);
         before_ff <= '0;
         used_ff   <= '0;
      end
      if (cmd.tb_chk) begin
         used_ff <= used_ff + (bt_rdata ? add_we : add_wg);
         if (line_end) begin
            end_ff      <= w_ff;
            line_brk_ff <= bt_rdata;
            i_ff        <= start_ff;
         end else begin
            before_ff <= before_ff + AW'(1);
            w_ff      <= w_ff + AW'(1);
         end
      end
      if (cmd.div_start) begin
         neg_ff <= left[UW];
      end
      if (cmd.emit) begin
         idx_ff     <= IndexBits'(i_ff);
         brk_out_ff <= line_brk_ff && (i_ff == end_ff);
         gset_ff    <= line_brk_ff && (i_ff != end_ff);
         glue_ff    <= (line_brk_ff && (i_ff != end_ff)) ? glue_sat : '0;
         last_ff    <= (CW'(i_ff) + CW'(1)) == count_ff;
         i_ff       <= i_ff + AW'(1);
      end
   end

   assign sts.row_end   = row_end;
   assign sts.w_zero    = w_ff == '0;
   assign sts.brk       = bt_rdata;
   assign sts.tb_final  = tb_final;
   assign sts.before_nz = before_ff != '0;
   assign sts.div_busy  = div_busy;
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;
   assign sts.emit_end  = i_ff == end_ff;
   assign sts.line_last = (CW'(end_ff) + CW'(1)) == count_ff;

   assign line_len        = lw_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_index   = idx_ff;
   assign rsp_line_break  = brk_out_ff;
   assign rsp_glue_set    = gset_ff;
   assign rsp_glue_out    = glue_ff;
   assign rsp_last_result = last_ff;
endmodule

[design/optimal_line_breaker_core.sv]
// Top level of the optimal line breaker: controller, datapath, APB port.
// Depends on olb_pkg, olb_req_if, olb_rsp_if, olb_ctrl, olb_dp.
//
// Boxes arrive on req_if, one word per box, taken one per cycle while the
// block is loading. The word with last_box set closes the paragraph; a box
// beyond MAX_BOXES is dropped, but its last_box still closes the paragraph.
// The block then fills the decision table one (box, position) pair at a
// time, with the shared cube multiplier and the single cost-row port. Trace
// back reads the table box by box and runs the divider once per broken line
// with more than one box. rsp_if carries one word per box in order, the
// final one flagged by last_result. A stalled receiver holds the output
// register and the emit sequencer waits on it; after the final word is
// loaded the sequencer passes its done state and req_if reopens. The line
// length register is written over APB at address 0 (only paddr[2] is
// decoded); the user must write it only while idle, as the block itself
// does not enforce it. Reset clears the box count, the line length and the
// output valid; the stores need no clearing.
module optimal_line_breaker_core #(
   parameter int MAX_BOXES = olb_pkg::MaxBoxesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   olb_req_if.sink                             req_if,
   olb_rsp_if.source                           rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [olb_pkg::CsrAddrBits-1:0]     paddr,
   input  logic [olb_pkg::CsrDataBits-1:0]     pwdata,
   output logic [olb_pkg::CsrDataBits-1:0]     prdata,
   output logic                                pready
);
   import olb_pkg::*;

   olb_cmd_type        cmd;
   olb_sts_type        sts;
   logic               cfg_we;
   logic [LenBits-1:0] line_len;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == CsrLineWidth);
   assign prdata = (paddr[2] == CsrLineWidth) ? CsrDataBits'(line_len) : '0;

   olb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_box),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   olb_dp #(.MaxBoxes(MAX_BOXES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .box_width       (req_if.box_width),
      .glue_nominal    (req_if.glue_nominal),
      .break_extra     (req_if.break_extra),
      .break_penalty   (req_if.break_penalty),
      .cfg_we          (cfg_we),
      .cfg_wdata       (pwdata[LenBits-1:0]),
      .line_len        (line_len),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_box_index   (rsp_if.box_index),
      .rsp_line_break  (rsp_if.line_break),
      .rsp_glue_set    (rsp_if.glue_set),
      .rsp_glue_out    (rsp_if.glue_out),
      .rsp_last_result (rsp_if.last_result)
   );

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> sts.before_nz)
      else $error("divider started with zero divisor");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free)
      else $error("result loaded over an untaken word");

   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.emit_end && sts.line_last) |=> ##1 req_if.ready)
      else $error("input not reopened after final result");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.pick || cmd.tb_chk || cmd.emit) |-> !req_if.ready)
      else $error("input open during computation");
endmodule

[verif/optimal_line_breaker_core_tb.sv]
// Self-checking testbench of optimal_line_breaker_core: box paragraphs are sent,
// layouts predicted by a dynamic program of its own and compared word by word.
// Depends on olb_pkg, olb_req_if, olb_rsp_if and the RTL of the core.
module optimal_line_breaker_core_tb;
   import olb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     NumBoxes  = 64;
   localparam longint CostTop   = 64'sh7FFF_FFFF_FFFF;
   localparam longint CostBot   = -CostTop - 1;
   localparam longint GlueTop   = 64'sh7F_FFFF;
   localparam longint GlueBot   = -GlueTop - 1;
   localparam int     IdleLimit = 200000;
   localparam int     AddrLineWidth = 0;
   localparam int     AddrUnused    = 4;

   typedef struct {
      logic [LenBits-1:0]        width;
      logic [LenBits-1:0]        glue;
      logic [LenBits-1:0]        extra;
      logic signed [LenBits-1:0] penalty;
   } box_type;

   typedef struct {
      logic [IndexBits-1:0]       index;
      logic                       brk;
      logic                       gset;
      logic signed [GlueBits-1:0] glue;
      logic                       last;
   } layout_word_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CsrAddrBits-1:0] paddr;
   logic [CsrDataBits-1:0] pwdata, prdata;

   olb_req_if req_if();
   olb_rsp_if rsp_if();

   optimal_line_breaker_core dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   box_type            paragraph[$];
   layout_word_type    layout_q[$];
   logic [LenBits-1:0] line_len;
   int                 errors;
   int                 burst_left;
   int                 idle_cycles = 0;
   int                 rx_run = 0;
   int                 rx_mode = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic longint clamp48(input longint v);
      if (v > CostTop) return CostTop;
      if (v < CostBot) return CostBot;
      return v;
   endfunction

   function automatic longint overflow(input longint wb, input longint x);
      longint lw, total, p;
      longint unsigned a, c;
      lw = line_len;
      total = wb + x;
      if (total <= lw) return 0;
      p = (wb > lw) ? x : total - lw;
      if (p == 0) return 0;
      a = 256 + p;
      c = (((a * a) >> 8) * a) >> 8;
      if (c > CostTop) return CostTop;
      return longint'(c);
   endfunction

   // fill the decision table bottom-up, then trace back from the first box
   task automatic lay_out_paragraph();
      longint          row_next[NumBoxes+1];
      longint          row_cur[NumBoxes+1];
      bit              brk_tab[NumBoxes][NumBoxes];
      layout_word_type words[NumBoxes];
      longint          lw, wb, width, wbrk, rest0, restn, slack, cb, cn, used, left, add, g;
      int              n, lead, start;
      lw = line_len;
      n = paragraph.size();
      foreach (row_next[i]) begin
         row_next[i] = 0;
         row_cur[i] = 0;
      end
      for (int w = n - 1; w >= 0; w--) begin
         wb = 0;
         width = paragraph[w].width;
         wbrk = width + paragraph[w].extra;
         for (int b = 0; b <= w; b++) begin
            if (b > 0) wb += paragraph[w-b].width + paragraph[w-b].glue;
            rest0 = (w + 1 < n) ? row_next[0] : 0;
            restn = (w + 1 < n) ? row_next[b+1] : 0;
            slack = (lw > wb + wbrk) ? lw - wb - wbrk : 0;
            cb = clamp48(longint'(paragraph[w].penalty) + overflow(wb, wbrk));
            cb = clamp48(cb + slack);
            cb = clamp48(cb + rest0);
            cn = clamp48(overflow(wb, width) + restn);
            brk_tab[w][b] = (cb < cn);
            row_cur[b] = (cb < cn) ? cb : cn;
         end
         row_next = row_cur;
      end
      lead = 0;
      for (int w = 0; w < n; w++) begin
         words[w].index = w[IndexBits-1:0];
         words[w].brk = brk_tab[w][lead];
         words[w].gset = 1'b0;
         words[w].glue = '0;
         words[w].last = (w + 1 == n);
         if (brk_tab[w][lead]) begin
            start = w - lead;
            used = 0;
            for (int i = start; i < w; i++) used += paragraph[i].width + paragraph[i].glue;
            used += paragraph[w].width + paragraph[w].extra;
            left = lw - used;
            if (lead > 0) begin
               add = left / lead;
               for (int i = start; i < w; i++) begin
                  g = longint'(paragraph[i].glue) + add;
                  if (g > GlueTop) g = GlueTop;
                  if (g < GlueBot) g = GlueBot;
                  words[i].gset = 1'b1;
                  words[i].glue = g[GlueBits-1:0];
               end
            end
            lead = 0;
         end else begin
            lead++;
         end
      end
      for (int w = 0; w < n; w++) layout_q = {layout_q, words[w]};
      paragraph.delete();
   endtask

   task automatic take_box(input box_type b, input bit last);
      if (paragraph.size() < NumBoxes) paragraph = {paragraph, b};
      if (last) lay_out_paragraph();
   endtask

   task automatic send_box(input box_type b, input bit last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid = 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.box_width = b.width;
      req_if.glue_nominal = b.glue;
      req_if.break_extra = b.extra;
      req_if.break_penalty = b.penalty;
      req_if.last_box = last;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      take_box(b, last);
   endtask

   task automatic apb_write(input int addr, input logic [CsrDataBits-1:0] data);
      @(negedge clock);
      req_if.valid = 1'b0;
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr[CsrAddrBits-1:0];
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == AddrLineWidth) line_len = data[LenBits-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic apb_check_read();
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b0;
      paddr = CsrAddrBits'(AddrLineWidth);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[LenBits-1:0] !== line_len)
         report($sformatf("line_len read %h, want %h", prdata, line_len));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // hold until every layout word has come back and the block is idle again
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (layout_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_line_len(input logic [LenBits-1:0] lw);
      drain();
      apb_write(AddrLineWidth, {16'h0, lw});
      apb_check_read();
   endtask

   function automatic box_type mk_box(input int w, input int g, input int x, input int p);
      box_type b;
      b.width = w[LenBits-1:0];
      b.glue = g[LenBits-1:0];
      b.extra = x[LenBits-1:0];
      b.penalty = p[LenBits-1:0];
      return b;
   endfunction

   function automatic box_type rand_box(input bit noise);
      int lim;
      lim = line_len / 4 + 256;
      if (noise)
         return mk_box($urandom, $urandom, $urandom, $urandom);
      return mk_box($urandom_range(0, lim), $urandom_range(0, lim / 2),
                    $urandom_range(0, 512), $urandom_range(0, 4096) - 2048);
   endfunction

   task automatic test_single_box();
      set_line_len(16'h1000);
      send_box(mk_box(0, 0, 0, 0), 1'b1);
      send_box(mk_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF), 1'b1);
   endtask

   task automatic test_extremes();
      set_line_len(16'hFFFF);
      send_box(mk_box(16'hFFFF, 0, 0, -32768), 1'b0);
      send_box(mk_box(0, 16'hFFFF, 16'hFFFF, 32767), 1'b0);
      send_box(mk_box(16'h4000, 16'h0100, 0, -32768), 1'b0);
      send_box(mk_box(16'h8000, 16'h0200, 16'h0100, 0), 1'b1);
      set_line_len(16'h0000);
      send_box(mk_box(16'h0100, 16'h0080, 0, 0), 1'b0);
      send_box(mk_box(16'h0200, 16'h0080, 16'h0040, -32768), 1'b0);
      send_box(mk_box(16'h0100, 0, 0, 0), 1'b1);
   endtask

   task automatic test_ties_and_negative_leftover();
      set_line_len(16'h0A00);
      repeat (3) send_box(mk_box(0, 0, 0, 0), 1'b0);
      send_box(mk_box(0, 0, 0, 0), 1'b1);
      send_box(mk_box(16'h0600, 16'h0100, 0, 0), 1'b0);
      send_box(mk_box(16'h0600, 16'h0100, 16'h0200, -32768), 1'b0);
      send_box(mk_box(16'h0300, 16'h0100, 0, -32768), 1'b0);
      send_box(mk_box(16'h0300, 16'h0100, 0, 0), 1'b1);
   endtask

   task automatic test_unused_register();
      drain();
      apb_write(AddrUnused, 32'h0000_1234);
      apb_check_read();
      send_box(mk_box(16'h0400, 16'h0080, 0, 0), 1'b0);
      send_box(mk_box(16'h0400, 16'h0080, 0, 0), 1'b1);
   endtask

   task automatic test_full_store();
      set_line_len(16'h2000);
      for (int i = 0; i < NumBoxes; i++)
         send_box(mk_box($urandom_range(256, 1024), $urandom_range(0, 256),
                         $urandom_range(0, 128), $urandom_range(0, 512) - 256), 1'b0);
      send_box(mk_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF), 1'b1);
   endtask

   task automatic test_random_paragraphs();
      int sent, size;
      bit noise;
      sent = 0;
      while (sent < 26) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: set_line_len(16'h0000);
               1: set_line_len(16'hFFFF);
               default: set_line_len(16'($urandom));
            endcase
         end
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
         noise = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < size; i++) send_box(rand_box(noise), i == size - 1);
         sent += size;
      end
   endtask

   always @(negedge clock) begin
      if (rx_run == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_run = $urandom_range(1, 40);
      end
      rx_run--;
      case (rx_mode)
         0, 1: rsp_if.ready = 1'b1;
         2: rsp_if.ready = 1'($urandom_range(0, 1));
         default: rsp_if.ready = 1'b0;
      endcase
   end

   always @(posedge clock) begin
      layout_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (layout_q.size() == 0) begin
            report($sformatf("unexpected word for box %0d", rsp_if.box_index));
         end else begin
            want = layout_q.pop_front();
            if (rsp_if.box_index !== want.index)
               report($sformatf("box_index %0d, want %0d", rsp_if.box_index, want.index));
            if (rsp_if.line_break !== want.brk)
               report($sformatf("box %0d line_break %b, want %b",
                                want.index, rsp_if.line_break, want.brk));
            if (rsp_if.glue_set !== want.gset)
               report($sformatf("box %0d glue_set %b, want %b",
                                want.index, rsp_if.glue_set, want.gset));
            if (rsp_if.glue_out !== want.glue)
               report($sformatf("box %0d glue_out %h, want %h",
                                want.index, rsp_if.glue_out, want.glue));
            if (rsp_if.last_result !== want.last)
               report($sformatf("box %0d last_result %b, want %b",
                                want.index, rsp_if.last_result, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("optimal_line_breaker_core_tb: FAIL");
         $finish;
      end
   end

   initial begin
      errors = 0;
      burst_left = 0;
      line_len = '0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.box_width = '0;
      req_if.glue_nominal = '0;
      req_if.break_extra = '0;
      req_if.break_penalty = '0;
      req_if.last_box = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_single_box();
      test_extremes();
      test_ties_and_negative_leftover();
      test_unused_register();
      test_full_store();
      test_random_paragraphs();
      drain();
      if (layout_q.size() != 0) report("layout words left over");
      if (errors == 0)
         $display("optimal_line_breaker_core_tb: PASS");
      else
         $display("optimal_line_breaker_core_tb: FAIL");
      $finish;
   end

endmodule

[files.f]
design/olb_pkg.sv
design/olb_req_if.sv
design/olb_rsp_if.sv
design/olb_ram.sv
design/olb_div.sv
design/olb_ctrl.sv
design/olb_dp.sv
design/optimal_line_breaker_core.sv
verif/optimal_line_breaker_core_tb.sv
